/* rtl/binary_to_decimal_ascii_formatter_core_defines.svh */
// Assertion macros for the decimal ASCII formatter
`ifndef BINARY_TO_DECIMAL_ASCII_FORMATTER_CORE_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_FORMATTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define BDAF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define BDAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bdaf_pkg.sv */
// Shared types and constants for the decimal ASCII formatter
`timescale 1ns / 1ps

package bdaf_pkg;

  localparam int unsigned NUM_DIGITS = 5;
  localparam int unsigned NUM_CHARS  = 6;
  localparam int unsigned MAG_W      = 17;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned LEN_W      = 3;
  localparam int unsigned CHAR_W     = 7;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0] ASCII_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] ASCII_NUL   = 7'h00;

  localparam logic [LEN_W-1:0] LEN_UBYTE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_SBYTE = 3'd4;
  localparam logic [LEN_W-1:0] LEN_UWORD = 3'd5;
  localparam logic [LEN_W-1:0] LEN_SWORD = 3'd6;

  // x / 10 == (x * 52429) >> 19, exact for x below 81920
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  typedef enum logic [1:0] {
    FMT_UBYTE = 2'd0,
    FMT_SBYTE = 2'd1,
    FMT_UWORD = 2'd2,
    FMT_SWORD = 2'd3
  } fmt_e;

  typedef struct packed {
    logic [MAG_W-1:0]                    mag;
    logic                                neg;
    logic [LEN_W-1:0]                    len;
    logic [LEN_W-1:0]                    ndig;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  digits;
  } conv_t;

endpackage

/* rtl/bdaf_digit_cell.sv */
// One cell of the digit chain: peels off one decimal digit per stage
`timescale 1ns / 1ps

module bdaf_digit_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  bdaf_pkg::conv_t data_i,
  output logic           valid_o,
  output bdaf_pkg::conv_t data_o
);

  logic [32:0]                   prod;
  logic [bdaf_pkg::MAG_W-1:0]    quot;
  logic [bdaf_pkg::MAG_W-1:0]    times10;
  logic [bdaf_pkg::DIGIT_W-1:0]  rem;
  logic                          present;
  bdaf_pkg::conv_t               data_d, data_q;
  logic                          valid_q;

  always_comb begin
    prod    = 33'(data_i.mag) * 33'(bdaf_pkg::DIV10_MUL);
    quot    = bdaf_pkg::MAG_W'(prod >> bdaf_pkg::DIV10_SHIFT);
    times10 = (quot << 3) + (quot << 1);
    rem     = bdaf_pkg::DIGIT_W'(data_i.mag - times10);
    // the units digit always shows, higher ones only while value remains
    present = (Idx == 0) || (data_i.mag != '0);

    data_d     = data_i;
    data_d.mag = quot;
    if (present) begin
      data_d.digits[Idx] = rem;
      data_d.ndig        = bdaf_pkg::LEN_W'(Idx + 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/bdaf_pack.sv */
// Lays digits, sign and padding into the right-aligned character slots
`timescale 1ns / 1ps

module bdaf_pack (
  input  bdaf_pkg::conv_t                                          conv_i,
  output logic [bdaf_pkg::LEN_W-1:0]                               text_length_o,
  output logic [bdaf_pkg::NUM_CHARS-1:0][bdaf_pkg::CHAR_W-1:0]     chars_o
);

  always_comb begin
    logic [bdaf_pkg::LEN_W-1:0] r;
    r = '0;
    for (int j = 0; j < bdaf_pkg::NUM_CHARS; j++) begin
      // r counts positions from the right end of the field
      r = conv_i.len - bdaf_pkg::LEN_W'(j + 1);
      if (bdaf_pkg::LEN_W'(j) >= conv_i.len) begin
        chars_o[j] = bdaf_pkg::ASCII_NUL;
      end else if (r < conv_i.ndig) begin
        chars_o[j] = bdaf_pkg::ASCII_ZERO + bdaf_pkg::CHAR_W'(conv_i.digits[r]);
      end else if (r == conv_i.ndig && conv_i.neg) begin
        chars_o[j] = bdaf_pkg::ASCII_MINUS;
      end else begin
        chars_o[j] = bdaf_pkg::ASCII_SPACE;
      end
    end
  end

  assign text_length_o = conv_i.len;

endmodule

/* rtl/binary_to_decimal_ascii_formatter_core.sv */
// Top level: binary to right-aligned decimal ASCII formatter
// Input channel (in_valid_i/in_ready_o) carries a 2-bit format selector and a
// 16-bit raw value; output channel (out_valid_o/out_ready_i) carries the text
// length and six 7-bit ASCII characters, leftmost first, unused slots zero.
// Formats: unsigned byte (3 chars), signed byte (4), unsigned word (5),
// signed word (6). Negative values get a minus just before the first digit.
// Registered path from input beat to output beat: five digit cells, each
// a divide-by-10 by reciprocal multiply, then the output register.
// Throughput is one beat per cycle while out_ready_i stays high; the five
// cells and the output register hold up to six beats in flight.
// When the receiver stalls with a result waiting, the whole chain holds and
// in_ready_o drops in the same cycle; it rises again with out_ready_i.
// Reset clears all valid flags; no result is pending after reset and there
// is no other state to initialize.
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_formatter_core_defines.svh"

module binary_to_decimal_ascii_formatter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  text_length_o,
  output logic [6:0]  char_0_o,
  output logic [6:0]  char_1_o,
  output logic [6:0]  char_2_o,
  output logic [6:0]  char_3_o,
  output logic [6:0]  char_4_o,
  output logic [6:0]  char_5_o
);

  logic                 en;
  bdaf_pkg::fmt_e       fmt;
  bdaf_pkg::conv_t      front;
  logic                 cell_valid [bdaf_pkg::NUM_DIGITS+1];
  bdaf_pkg::conv_t      cell_data  [bdaf_pkg::NUM_DIGITS+1];

  logic [bdaf_pkg::LEN_W-1:0]                           pack_len;
  logic [bdaf_pkg::NUM_CHARS-1:0][bdaf_pkg::CHAR_W-1:0] pack_chars;

  logic                                                 out_valid_q;
  logic [bdaf_pkg::LEN_W-1:0]                           len_q;
  logic [bdaf_pkg::NUM_CHARS-1:0][bdaf_pkg::CHAR_W-1:0] chars_q;

  logic                                                 in_beat;
  logic [bdaf_pkg::CHAR_W-1:0]                          last_char;
  logic                                                 last_is_digit;
  logic                                                 slot5_clear;

  // whole chain moves unless a finished beat sits unclaimed
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // format decode and magnitude; most-negative values keep their sign and full magnitude
  always_comb begin
    fmt          = bdaf_pkg::fmt_e'(action_i);
    front        = '0;
    case (fmt)
      bdaf_pkg::FMT_UBYTE: begin
        front.len = bdaf_pkg::LEN_UBYTE;
        front.mag = bdaf_pkg::MAG_W'(value_i[7:0]);
      end
      bdaf_pkg::FMT_SBYTE: begin
        front.len = bdaf_pkg::LEN_SBYTE;
        front.neg = value_i[7];
        if (value_i[7]) begin
          front.mag = bdaf_pkg::MAG_W'(9'h100 - {1'b0, value_i[7:0]});
        end else begin
          front.mag = bdaf_pkg::MAG_W'(value_i[7:0]);
        end
      end
      bdaf_pkg::FMT_UWORD: begin
        front.len = bdaf_pkg::LEN_UWORD;
        front.mag = bdaf_pkg::MAG_W'(value_i);
      end
      bdaf_pkg::FMT_SWORD: begin
        front.len = bdaf_pkg::LEN_SWORD;
        front.neg = value_i[15];
        if (value_i[15]) begin
          front.mag = 17'h10000 - bdaf_pkg::MAG_W'(value_i);
        end else begin
          front.mag = bdaf_pkg::MAG_W'(value_i);
        end
      end
      default: begin
        front.len = bdaf_pkg::LEN_UBYTE;
      end
    endcase
  end

  assign cell_valid[0] = in_valid_i;
  assign cell_data[0]  = front;

  for (genvar i = 0; i < bdaf_pkg::NUM_DIGITS; i++) begin : g_cell
    bdaf_digit_cell #(
      .Idx (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cell_valid[i]),
      .data_i  (cell_data[i]),
      .valid_o (cell_valid[i+1]),
      .data_o  (cell_data[i+1])
    );
  end

  bdaf_pack u_pack (
    .conv_i        (cell_data[bdaf_pkg::NUM_DIGITS]),
    .text_length_o (pack_len),
    .chars_o       (pack_chars)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cell_valid[bdaf_pkg::NUM_DIGITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      len_q   <= pack_len;
      chars_q <= pack_chars;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign text_length_o = len_q;
  assign char_0_o      = chars_q[0];
  assign char_1_o      = chars_q[1];
  assign char_2_o      = chars_q[2];
  assign char_3_o      = chars_q[3];
  assign char_4_o      = chars_q[4];
  assign char_5_o      = chars_q[5];

  // rightmost character of the field, picked by text length
  always_comb begin
    case (text_length_o)
      bdaf_pkg::LEN_UBYTE: last_char = char_2_o;
      bdaf_pkg::LEN_SBYTE: last_char = char_3_o;
      bdaf_pkg::LEN_UWORD: last_char = char_4_o;
      bdaf_pkg::LEN_SWORD: last_char = char_5_o;
      default:             last_char = bdaf_pkg::ASCII_NUL;
    endcase
  end

  assign in_beat       = in_valid_i && in_ready_o;
  assign last_is_digit = last_char inside {[bdaf_pkg::ASCII_ZERO:bdaf_pkg::ASCII_NINE]};
  assign slot5_clear   = (text_length_o == bdaf_pkg::LEN_SWORD) ||
                         (char_5_o == bdaf_pkg::ASCII_NUL);

  `BDAF_ASSERT_NEXT(a_accept_enters_chain, in_beat, cell_valid[1], "beat did not enter the chain")
  `BDAF_ASSERT_NOW(a_last_char_digit, out_valid_o, last_is_digit, "last character not a digit")
  `BDAF_ASSERT_NOW(a_unused_slots_zero, out_valid_o, slot5_clear, "slot past text end not zero")

endmodule
